FILE: rtl/core/svg_pkg.sv
package svg_pkg;

  localparam int MAX_VERTICES  = 16;
  localparam int TABLE_ENTRIES = 256;

  localparam int ANGLE_W = $clog2(TABLE_ENTRIES);
  localparam int IDX_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);

  localparam int SCALE_W = 8;
  localparam int TRIG_W  = 10;  // -256..256
  localparam int PROD_W  = 18;  // trig * scale
  localparam int FRAC_BITS = 8;

  localparam int X_W   = 9;
  localparam int Y_W   = 8;
  localparam int OIDX_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int VCOUNT_W   = 5;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(TABLE_ENTRIES / 4);
  localparam logic signed [10:0] CENTRE_X = 11'sd160;
  localparam logic signed [10:0] CENTRE_Y = 11'sd120;
  localparam logic signed [10:0] LIMIT_X  = 11'sd319;
  localparam logic signed [10:0] LIMIT_Y  = 11'sd239;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd10;
  localparam logic [ANGLE_W-1:0]  STEP_RESET   = ANGLE_W'(26);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_COUNT = 2'd0,
    REG_ANGLE_STEP   = 2'd1
  } cfg_reg_t;

  // per-vertex side information carried down the pipe
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             odd;
  } vtx_ctl_t;

  // sine, zero to a quarter turn inclusive
  localparam logic [8:0] QUARTER_WAVE [0:64] = '{
    9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,
    9'd49,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
    9'd97,  9'd103, 9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136,
    9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd171, 9'd176,
    9'd181, 9'd185, 9'd189, 9'd193, 9'd197, 9'd201, 9'd205, 9'd209,
    9'd212, 9'd216, 9'd219, 9'd222, 9'd225, 9'd228, 9'd231, 9'd234,
    9'd236, 9'd238, 9'd241, 9'd243, 9'd244, 9'd246, 9'd248, 9'd249,
    9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255,
    9'd256
  };

  function automatic logic signed [TRIG_W-1:0] sine_of(input logic [7:0] angle);
    logic [7:0] half;
    logic [9:0] mag;
    half = {1'b0, angle[6:0]};
    if (half > 8'd64) begin
      half = 8'd128 - half;
    end
    mag = {1'b0, QUARTER_WAVE[half[6:0]]};
    sine_of = angle[7] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

FILE: rtl/core/star_vertex_generator.sv
// Star vertex generator.
// Input channel (in_*): one request per item, start angle and scale.
// Result channel (out_*): vertex_count vertices per request in index order,
// out_tlast high on the final one. Config channel (cfg_*): index 0 is
// vertex_count (low five bits, saturated to 16 vertices, zero gives no
// vertices), index 1 is angle_step; other indexes are ignored. cfg_ready
// is always high; write only while the block is idle.
// Throughput: one vertex per cycle while out_tready is high; a request holds
// the input until its vertices have left the sequencer, and the next request
// is taken in the cycle the last vertex of the current one leaves the sequencer.
// Each vertex passes the sequencer, table lookup, multiply and shift/centre/clamp
// registers in that order before it appears on out_*.
// Reset (rst_n low, synchronous) empties the pipe, drops any request in
// progress and restores vertex_count 10 and angle_step 26.
// A stalled receiver holds the output register; each stage only moves when
// the one after it has room, so nothing is lost or repeated, and with the
// pipe full the input stops being taken.
module star_vertex_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // start_angle[7:0], scale[15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // vertex_x[8:0], vertex_y[16:9], vertex_index[20:17], zero
  output logic        out_tlast
);

  logic                              seq_valid;
  logic                              seq_ready;
  logic [svg_pkg::ANGLE_W-1:0]       seq_angle;
  logic [svg_pkg::SCALE_W-1:0]       seq_scale;
  svg_pkg::vtx_ctl_t                 seq_ctl;

  logic                              trig_valid;
  logic                              trig_ready;
  logic signed [svg_pkg::TRIG_W-1:0] trig_sin;
  logic signed [svg_pkg::TRIG_W-1:0] trig_cos;
  logic [svg_pkg::SCALE_W-1:0]       trig_scale;
  svg_pkg::vtx_ctl_t                 trig_ctl;

  logic                              mul_valid;
  logic                              mul_ready;
  logic signed [svg_pkg::PROD_W-1:0] mul_px;
  logic signed [svg_pkg::PROD_W-1:0] mul_py;
  svg_pkg::vtx_ctl_t                 mul_ctl;

  logic [svg_pkg::X_W-1:0]           vx;
  logic [svg_pkg::Y_W-1:0]           vy;
  logic [svg_pkg::OIDX_W-1:0]        vidx;

  svg_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_angle (in_tdata[7:0]),
    .req_scale (in_tdata[15:8]),
    .vtx_valid (seq_valid),
    .vtx_ready (seq_ready),
    .vtx_angle (seq_angle),
    .vtx_scale (seq_scale),
    .vtx_ctl   (seq_ctl)
  );

  svg_trig u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (seq_valid),
    .s_ready (seq_ready),
    .s_angle (seq_angle),
    .s_scale (seq_scale),
    .s_ctl   (seq_ctl),
    .m_valid (trig_valid),
    .m_ready (trig_ready),
    .m_sin   (trig_sin),
    .m_cos   (trig_cos),
    .m_scale (trig_scale),
    .m_ctl   (trig_ctl)
  );

  svg_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (trig_valid),
    .s_ready (trig_ready),
    .s_sin   (trig_sin),
    .s_cos   (trig_cos),
    .s_scale (trig_scale),
    .s_ctl   (trig_ctl),
    .m_valid (mul_valid),
    .m_ready (mul_ready),
    .m_px    (mul_px),
    .m_py    (mul_py),
    .m_ctl   (mul_ctl)
  );

  svg_place u_place (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (mul_valid),
    .s_ready (mul_ready),
    .s_px    (mul_px),
    .s_py    (mul_py),
    .s_ctl   (mul_ctl),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_x     (vx),
    .m_y     (vy),
    .m_idx   (vidx),
    .m_last  (out_tlast)
  );

  assign out_tdata = {3'b000, vidx, vy, vx};

endmodule

FILE: rtl/core/svg_seq.sv
module svg_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [svg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [svg_pkg::ANGLE_W-1:0]    req_angle,
  input  logic [svg_pkg::SCALE_W-1:0]    req_scale,
  output logic                           vtx_valid,
  input  logic                           vtx_ready,
  output logic [svg_pkg::ANGLE_W-1:0]    vtx_angle,
  output logic [svg_pkg::SCALE_W-1:0]    vtx_scale,
  output svg_pkg::vtx_ctl_t              vtx_ctl
);

  logic [svg_pkg::VCOUNT_W-1:0] vcount_r;
  logic [svg_pkg::ANGLE_W-1:0]  step_r;
  logic                         busy_r;
  logic [svg_pkg::ANGLE_W-1:0]  angle_r;
  logic [svg_pkg::SCALE_W-1:0]  scale_r;
  logic [svg_pkg::IDX_W-1:0]    idx_r;
  logic [svg_pkg::CNT_W-1:0]    count_r;
  logic [svg_pkg::CNT_W-1:0]    count_nxt;
  logic [svg_pkg::CNT_W-1:0]    vc_ext;
  logic                         is_last;
  logic                         emit;
  logic                         take;

  assign cfg_ready = 1'b1;

  // saturate the register to the largest star
  always_comb begin
    vc_ext = svg_pkg::CNT_W'(vcount_r);
    if ((svg_pkg::VCOUNT_W + 1) > svg_pkg::CNT_W &&
        32'(vcount_r) > 32'(svg_pkg::MAX_VERTICES)) begin
      count_nxt = svg_pkg::CNT_W'(svg_pkg::MAX_VERTICES);
    end else begin
      count_nxt = vc_ext;
    end
  end

  assign is_last   = (svg_pkg::CNT_W'(idx_r) + svg_pkg::CNT_W'(1)) == count_r;
  assign emit      = busy_r && vtx_ready;
  assign req_ready = !busy_r || (emit && is_last);
  assign take      = req_valid && req_ready;

  assign vtx_valid   = busy_r;
  assign vtx_angle   = angle_r;
  assign vtx_scale   = scale_r;
  assign vtx_ctl.idx  = idx_r;
  assign vtx_ctl.last = is_last;
  assign vtx_ctl.odd  = idx_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= svg_pkg::VCOUNT_RESET;
      step_r   <= svg_pkg::STEP_RESET;
      busy_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          svg_pkg::REG_VERTEX_COUNT: vcount_r <= cfg_data[svg_pkg::VCOUNT_W-1:0];
          svg_pkg::REG_ANGLE_STEP:   step_r   <= cfg_data[svg_pkg::ANGLE_W-1:0];
          default: ;
        endcase
      end
      if (take) begin
        busy_r <= (count_nxt != '0);
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      angle_r <= req_angle;
      scale_r <= req_scale;
      idx_r   <= '0;
      count_r <= count_nxt;
    end else if (emit) begin
      angle_r <= angle_r + step_r;
      idx_r   <= idx_r + svg_pkg::IDX_W'(1);
    end
  end

endmodule

FILE: rtl/core/svg_trig.sv
module svg_trig (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s_valid,
  output logic                              s_ready,
  input  logic [svg_pkg::ANGLE_W-1:0]       s_angle,
  input  logic [svg_pkg::SCALE_W-1:0]       s_scale,
  input  svg_pkg::vtx_ctl_t                 s_ctl,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic signed [svg_pkg::TRIG_W-1:0] m_sin,
  output logic signed [svg_pkg::TRIG_W-1:0] m_cos,
  output logic [svg_pkg::SCALE_W-1:0]       m_scale,
  output svg_pkg::vtx_ctl_t                 m_ctl
);

  logic valid_r;
  logic load;

  assign s_ready = !valid_r || m_ready;
  assign load    = s_valid && s_ready;
  assign m_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_sin   <= svg_pkg::sine_of(s_angle);
      m_cos   <= svg_pkg::sine_of(s_angle + svg_pkg::QUARTER_TURN);
      m_scale <= s_scale;
      m_ctl   <= s_ctl;
    end
  end

endmodule

FILE: rtl/core/svg_mul.sv
module svg_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s_valid,
  output logic                              s_ready,
  input  logic signed [svg_pkg::TRIG_W-1:0] s_sin,
  input  logic signed [svg_pkg::TRIG_W-1:0] s_cos,
  input  logic [svg_pkg::SCALE_W-1:0]       s_scale,
  input  svg_pkg::vtx_ctl_t                 s_ctl,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic signed [svg_pkg::PROD_W-1:0] m_px,
  output logic signed [svg_pkg::PROD_W-1:0] m_py,
  output svg_pkg::vtx_ctl_t                 m_ctl
);

  logic                              valid_r;
  logic                              load;
  logic signed [svg_pkg::SCALE_W:0]  scale_s;
  logic signed [svg_pkg::PROD_W-1:0] px_nxt;
  logic signed [svg_pkg::PROD_W-1:0] py_nxt;

  assign s_ready = !valid_r || m_ready;
  assign load    = s_valid && s_ready;
  assign m_valid = valid_r;
  assign scale_s = $signed({1'b0, s_scale});
  assign px_nxt  = s_sin * scale_s;
  assign py_nxt  = s_cos * scale_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_px  <= px_nxt;
      m_py  <= py_nxt;
      m_ctl <= s_ctl;
    end
  end

endmodule

FILE: rtl/core/svg_place.sv
module svg_place (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s_valid,
  output logic                              s_ready,
  input  logic signed [svg_pkg::PROD_W-1:0] s_px,
  input  logic signed [svg_pkg::PROD_W-1:0] s_py,
  input  svg_pkg::vtx_ctl_t                 s_ctl,
  output logic                              m_valid,
  input  logic                              m_ready,
  output logic [svg_pkg::X_W-1:0]           m_x,
  output logic [svg_pkg::Y_W-1:0]           m_y,
  output logic [svg_pkg::OIDX_W-1:0]        m_idx,
  output logic                              m_last
);

  logic                              valid_r;
  logic                              load;
  logic signed [svg_pkg::PROD_W-1:0] shx;
  logic signed [svg_pkg::PROD_W-1:0] shy;
  logic signed [10:0]                ox;
  logic signed [10:0]                oy;
  logic [svg_pkg::X_W-1:0]           x_nxt;
  logic [svg_pkg::Y_W-1:0]           y_nxt;
  logic [svg_pkg::IDX_W+svg_pkg::OIDX_W-1:0] idx_ext;

  assign s_ready = !valid_r || m_ready;
  assign load    = s_valid && s_ready;
  assign m_valid = valid_r;

  // floor by 256, odd vertices floor by a further two
  assign shx = s_ctl.odd ? (s_px >>> (svg_pkg::FRAC_BITS + 1)) : (s_px >>> svg_pkg::FRAC_BITS);
  assign shy = s_ctl.odd ? (s_py >>> (svg_pkg::FRAC_BITS + 1)) : (s_py >>> svg_pkg::FRAC_BITS);
  assign ox  = $signed({shx[9], shx[9:0]}) + svg_pkg::CENTRE_X;
  assign oy  = $signed({shy[9], shy[9:0]}) + svg_pkg::CENTRE_Y;
  assign idx_ext = (svg_pkg::IDX_W + svg_pkg::OIDX_W)'(s_ctl.idx);

  always_comb begin
    if (ox < 0) begin
      x_nxt = '0;
    end else if (ox > svg_pkg::LIMIT_X) begin
      x_nxt = svg_pkg::LIMIT_X[svg_pkg::X_W-1:0];
    end else begin
      x_nxt = ox[svg_pkg::X_W-1:0];
    end
    if (oy < 0) begin
      y_nxt = '0;
    end else if (oy > svg_pkg::LIMIT_Y) begin
      y_nxt = svg_pkg::LIMIT_Y[svg_pkg::Y_W-1:0];
    end else begin
      y_nxt = oy[svg_pkg::Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_x    <= x_nxt;
      m_y    <= y_nxt;
      m_idx  <= idx_ext[svg_pkg::OIDX_W-1:0];
      m_last <= s_ctl.last;
    end
  end

endmodule
